/* hw/rtl/uniform_grid_neighbor_binning_defines.svh */
// Assertion macros used by the grid binning RTL.
// No dependencies; included by modules that carry assertions.
`ifndef UNIFORM_GRID_NEIGHBOR_BINNING_DEFINES_SVH
`define UNIFORM_GRID_NEIGHBOR_BINNING_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define UGNB_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define UGNB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/ugnb_pkg.sv */
// Types, codes and fixed widths of the uniform grid neighbor binning block.
// No dependencies; imported by every module of the block but ugnb_ram.
package ugnb_pkg;

   localparam int FRAC_BITS  = 8;
   localparam int POS_W      = 24;
   localparam int INT_W      = POS_W - FRAC_BITS;
   localparam int DIV_CNT_W  = $clog2(INT_W);
   localparam int ITEM_W     = 12;
   localparam int STATUS_W   = 3;
   localparam int CFG_W      = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int CELL_NUM_W = 16;   // holds any cell number up to 65535
   localparam int CNT_W      = 5;    // holds any cell count up to 16
   localparam int TOT_W      = CNT_W + 2;

   typedef enum logic [1:0] {
      MODE_ADD    = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_QUERY  = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ENTRY   = 3'd0,
      ST_EMPTY   = 3'd1,
      ST_ADDED   = 3'd2,
      ST_REMOVED = 3'd3,
      ST_FULL    = 3'd4,
      ST_RANGE   = 3'd5
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CELL_SIZE        = 2'd0,
      CSR_CELLS_PER_ROW    = 2'd1,
      CSR_CELLS_PER_COLUMN = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [CFG_W-1:0] cell_size;
      logic [CFG_W-1:0] cells_per_row;
      logic [CFG_W-1:0] cells_per_column;
   } cfg_type;

   // Classified command: cell 0 is the home cell, then horizontal,
   // vertical and diagonal neighbor.
   typedef struct packed {
      mode_type                   mode;
      logic [ITEM_W-1:0]          item;
      logic                       range_err;
      logic [3:0]                 cell_ok;
      logic [3:0][CELL_NUM_W-1:0] cell_num;
   } cmd_type;

   typedef struct packed {
      status_type        status;
      logic [ITEM_W-1:0] index;
      logic              last;
   } rsp_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_DIV,
      F_MUL,
      F_PUSH
   } front_state_type;

   typedef enum logic [3:0] {
      B_CLEAR,
      B_IDLE,
      B_CRD,
      B_CWAIT,
      B_ADD,
      B_RRD,
      B_RCMP,
      B_RFIN,
      B_QSUM,
      B_QNEXT,
      B_QRD,
      B_QDAT,
      B_ONE
   } back_state_type;

endpackage

/* hw/rtl/ugnb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ugnb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/ugnb_front.sv */
// Front end: accepts request beats, finds cell and neighbor cells.
// Depends on ugnb_pkg.
module ugnb_front import ugnb_pkg::*; #(
   parameter int MAX_CELLS = 1024,
   parameter int MAX_ITEMS = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              clear_done,
   input  logic              req_valid,
   output logic              req_ready,
   input  mode_type          req_mode,
   input  logic [ITEM_W-1:0] req_item,
   input  logic [POS_W-1:0]  req_x,
   input  logic [POS_W-1:0]  req_y,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output cmd_type           cmd
);

   localparam int AW = 24;
   localparam logic [AW-1:0] MAXC = AW'(MAX_CELLS);

   front_state_type state_ff, state_in;

   mode_type               mode_ff;
   logic [ITEM_W-1:0]      item_ff;
   logic [INT_W-1:0]       xd_ff, yd_ff;
   logic [CFG_W-1:0]       xr_ff, yr_ff;
   logic                   xf_ff, yf_ff, zero_ff;
   logic [DIV_CNT_W-1:0]   bit_ff;
   logic [2*CFG_W-1:0]     prod_ff;
   logic                   right_ff, top_ff, col_ok_ff, row_ok_ff;

   logic [CFG_W:0]   cs_ext, xs, ys, r2x, r2y;
   logic             xge, yge;
   logic [CFG_W-1:0] xr_step, yr_step;
   logic             accept;

   assign accept = req_valid && req_ready;
   assign cs_ext = {1'b0, cfg.cell_size};

   // one restoring division step per cycle for both axes
   always_comb begin
      xs      = {xr_ff, xd_ff[INT_W-1]};
      ys      = {yr_ff, yd_ff[INT_W-1]};
      xge     = xs >= cs_ext;
      yge     = ys >= cs_ext;
      xr_step = xge ? CFG_W'(xs - cs_ext) : xs[CFG_W-1:0];
      yr_step = yge ? CFG_W'(ys - cs_ext) : ys[CFG_W-1:0];
      r2x     = {xr_ff, 1'b0};
      r2y     = {yr_ff, 1'b0};
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE: if (accept && req_mode != MODE_NONE) state_in = F_DIV;
         F_DIV:  if (bit_ff == DIV_CNT_W'(INT_W - 1)) state_in = F_MUL;
         F_MUL:  state_in = F_PUSH;
         F_PUSH: if (cmd_ready) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd_valid = 1'b0;
      unique case (state_ff)
         F_IDLE: req_ready = clear_done;
         F_PUSH: cmd_valid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_mode;
         item_ff <= req_item;
         xd_ff   <= req_x[POS_W-1:FRAC_BITS];
         yd_ff   <= req_y[POS_W-1:FRAC_BITS];
         xf_ff   <= req_x[FRAC_BITS-1];
         yf_ff   <= req_y[FRAC_BITS-1];
         xr_ff   <= '0;
         yr_ff   <= '0;
         zero_ff <= cfg.cell_size == '0;
         bit_ff  <= '0;
      end else if (state_ff == F_DIV) begin
         xd_ff  <= {xd_ff[INT_W-2:0], xge};
         yd_ff  <= {yd_ff[INT_W-2:0], yge};
         xr_ff  <= xr_step;
         yr_ff  <= yr_step;
         bit_ff <= bit_ff + 1'b1;
      end
      if (state_ff == F_MUL) begin
         prod_ff   <= yd_ff[CFG_W-1:0] * cfg.cells_per_row;
         col_ok_ff <= xd_ff < INT_W'(cfg.cells_per_row);
         row_ok_ff <= yd_ff < INT_W'(cfg.cells_per_column);
         // upper half: fraction times two reaches the span
         right_ff  <= (r2x >= cs_ext) || ((r2x + 1'b1 == cs_ext) && xf_ff);
         top_ff    <= (r2y >= cs_ext) || ((r2y + 1'b1 == cs_ext) && yf_ff);
      end
   end

   // neighbor classification from the registered product
   logic [AW-1:0] c0, c1, c2, c3, cpr, col, row;
   logic          in_ok, h_ok, v_ok, item_bad;

   always_comb begin
      cpr = AW'(cfg.cells_per_row);
      col = AW'(xd_ff);
      row = AW'(yd_ff);
      c0  = AW'(prod_ff) + col;
      c1  = right_ff ? c0 + 1'b1 : c0 - 1'b1;
      c2  = top_ff ? c0 - cpr : c0 + cpr;
      c3  = right_ff ? c2 + 1'b1 : c2 - 1'b1;
      in_ok = !zero_ff && col_ok_ff && row_ok_ff && (c0 < MAXC);
      h_ok  = right_ff ? (col + 1'b1 < cpr) : (col != '0);
      v_ok  = top_ff ? (row != '0) : (row + 1'b1 < AW'(cfg.cells_per_column));
      item_bad = (mode_ff != MODE_QUERY) && (32'(item_ff) >= 32'(MAX_ITEMS));
      cmd.mode        = mode_ff;
      cmd.item        = item_ff;
      cmd.range_err   = !in_ok || item_bad;
      cmd.cell_ok[0]  = 1'b1;
      cmd.cell_ok[1]  = h_ok && (c1 < MAXC);
      cmd.cell_ok[2]  = v_ok && (c2 < MAXC);
      cmd.cell_ok[3]  = h_ok && v_ok && (c3 < MAXC);
      cmd.cell_num[0] = c0[CELL_NUM_W-1:0];
      cmd.cell_num[1] = c1[CELL_NUM_W-1:0];
      cmd.cell_num[2] = c2[CELL_NUM_W-1:0];
      cmd.cell_num[3] = c3[CELL_NUM_W-1:0];
   end

endmodule

/* hw/rtl/ugnb_queue.sv */
// Two-slot command queue between front and back end.
// Depends on ugnb_pkg.
module ugnb_queue import ugnb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  cmd_type in_cmd,
   output logic    out_valid,
   input  logic    out_ready,
   output cmd_type out_cmd
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] fill_ff;
   logic       push, pop;

   assign in_ready  = fill_ff != 2'd2;
   assign out_valid = fill_ff != 2'd0;
   assign out_cmd   = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         fill_ff <= fill_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= in_cmd;
   end

endmodule

/* hw/rtl/ugnb_back.sv */
// Back end: cell store, add, compacting remove and neighbor query.
// Depends on ugnb_pkg, ugnb_ram and the assertion macro header.
`include "uniform_grid_neighbor_binning_defines.svh"
module ugnb_back import ugnb_pkg::*; #(
   parameter int MAX_CELLS     = 1024,
   parameter int CELL_CAPACITY = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_ready,
   input  cmd_type cmd,
   output logic    clear_done,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp
);

   localparam int CELL_W    = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
   localparam int ENT_DEPTH = MAX_CELLS * CELL_CAPACITY;
   localparam int EADDR_W   = (ENT_DEPTH > 1) ? $clog2(ENT_DEPTH) : 1;
   localparam logic [CNT_W-1:0]  CAP_CNT  = CNT_W'(CELL_CAPACITY);
   localparam logic [CELL_W-1:0] LAST_CLR = CELL_W'(MAX_CELLS - 1);

   back_state_type state_ff, state_in;

   cmd_type                 cmd_ff;
   logic [CELL_W-1:0]       clr_ff;
   logic [1:0]              sel_ff;
   logic [3:0][CNT_W-1:0]   cnt_ff;
   logic [CNT_W-1:0]        k_ff, w_ff;
   logic [TOT_W-1:0]        emit_ff, total_ff;
   status_type              one_ff;
   logic                    out_v_ff;
   rsp_type                 out_ff;

   logic                cnt_wr_en;
   logic [CELL_W-1:0]   cnt_wr_addr, cnt_rd_addr;
   logic [CNT_W-1:0]    cnt_wr_data, cnt_rd_data;
   logic                ent_wr_en;
   logic [EADDR_W-1:0]  ent_wr_addr, ent_rd_addr;
   logic [ITEM_W-1:0]   ent_wr_data, ent_rd_data;
   logic                out_load;
   rsp_type             out_in;
   logic [CELL_W-1:0]   home, cur;
   logic [TOT_W-1:0]    sum;
   logic                final_beat;

   assign home = cmd_ff.cell_num[0][CELL_W-1:0];
   assign cur  = cmd_ff.cell_num[sel_ff][CELL_W-1:0];
   assign sum  = TOT_W'(cnt_ff[0]) + TOT_W'(cnt_ff[1]) + TOT_W'(cnt_ff[2])
               + TOT_W'(cnt_ff[3]);
   assign final_beat = emit_ff + 1'b1 == total_ff;

   ugnb_ram #(.WIDTH(CNT_W), .DEPTH(MAX_CELLS)) u_counts (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_addr (cnt_rd_addr),
      .rd_data (cnt_rd_data)
   );

   ugnb_ram #(.WIDTH(ITEM_W), .DEPTH(ENT_DEPTH)) u_entries (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (ent_wr_addr),
      .wr_data (ent_wr_data),
      .rd_addr (ent_rd_addr),
      .rd_data (ent_rd_data)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_CLEAR: if (clr_ff == LAST_CLR) state_in = B_IDLE;
         B_IDLE:  if (cmd_valid) state_in = cmd.range_err ? B_ONE : B_CRD;
         B_CRD:   state_in = B_CWAIT;
         B_CWAIT: begin
            unique case (cmd_ff.mode)
               MODE_ADD:    state_in = B_ADD;
               MODE_REMOVE: state_in = (cnt_rd_data == '0) ? B_RFIN : B_RRD;
               default:     state_in = (sel_ff == 2'd3) ? B_QSUM : B_CRD;
            endcase
         end
         B_ADD:   state_in = B_ONE;
         B_RRD:   state_in = B_RCMP;
         B_RCMP:  state_in = (k_ff + 1'b1 == cnt_ff[0]) ? B_RFIN : B_RRD;
         B_RFIN:  state_in = B_ONE;
         B_QSUM:  state_in = (sum == '0) ? B_ONE : B_QNEXT;
         B_QNEXT: if (k_ff < cnt_ff[sel_ff]) state_in = B_QRD;
         B_QRD:   if (!out_v_ff) state_in = B_QDAT;
         B_QDAT:  state_in = final_beat ? B_IDLE : B_QNEXT;
         B_ONE:   if (!out_v_ff) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      cmd_ready   = 1'b0;
      cnt_wr_en   = 1'b0;
      cnt_wr_addr = home;
      cnt_wr_data = '0;
      cnt_rd_addr = cur;
      ent_wr_en   = 1'b0;
      ent_wr_addr = EADDR_W'(home * CELL_CAPACITY + k_ff);
      ent_wr_data = cmd_ff.item;
      ent_rd_addr = EADDR_W'(cur * CELL_CAPACITY + k_ff);
      out_load    = 1'b0;
      out_in      = '{status: one_ff, index: '0, last: 1'b1};
      unique case (state_ff)
         B_CLEAR: begin
            cnt_wr_en   = 1'b1;
            cnt_wr_addr = clr_ff;
         end
         B_IDLE: cmd_ready = 1'b1;
         B_ADD: begin
            // append at the current count unless the cell is full
            if (cnt_ff[0] < CAP_CNT) begin
               cnt_wr_en   = 1'b1;
               cnt_wr_data = cnt_ff[0] + 1'b1;
               ent_wr_en   = 1'b1;
               ent_wr_addr = EADDR_W'(home * CELL_CAPACITY + cnt_ff[0]);
            end
         end
         // remove scans the home cell only
         B_RRD: ent_rd_addr = EADDR_W'(home * CELL_CAPACITY + k_ff);
         B_RCMP: begin
            // keep entries that differ, packed down to the write slot
            if (ent_rd_data != cmd_ff.item) begin
               ent_wr_en   = 1'b1;
               ent_wr_addr = EADDR_W'(home * CELL_CAPACITY + w_ff);
               ent_wr_data = ent_rd_data;
            end
         end
         B_RFIN: begin
            cnt_wr_en   = 1'b1;
            cnt_wr_data = w_ff;
         end
         B_QDAT: begin
            out_load = 1'b1;
            out_in   = '{status: ST_ENTRY, index: ent_rd_data, last: final_beat};
         end
         B_ONE: out_load = !out_v_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_CLEAR;
         clr_ff   <= '0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == B_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (out_load) begin
            out_v_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) out_ff <= out_in;
      case (state_ff)
         B_IDLE: begin
            cmd_ff <= cmd;
            sel_ff <= '0;
            k_ff   <= '0;
            w_ff   <= '0;
            one_ff <= ST_RANGE;
         end
         B_CWAIT: begin
            cnt_ff[sel_ff] <= cmd_ff.cell_ok[sel_ff] ? cnt_rd_data : '0;
            sel_ff         <= sel_ff + 1'b1;
         end
         B_ADD: one_ff <= (cnt_ff[0] < CAP_CNT) ? ST_ADDED : ST_FULL;
         B_RCMP: begin
            k_ff <= k_ff + 1'b1;
            if (ent_rd_data != cmd_ff.item) w_ff <= w_ff + 1'b1;
         end
         B_RFIN: one_ff <= ST_REMOVED;
         B_QSUM: begin
            total_ff <= sum;
            emit_ff  <= '0;
            sel_ff   <= '0;
            k_ff     <= '0;
            one_ff   <= ST_EMPTY;
         end
         B_QNEXT: begin
            if (k_ff >= cnt_ff[sel_ff]) begin
               sel_ff <= sel_ff + 1'b1;
               k_ff   <= '0;
            end
         end
         B_QDAT: begin
            emit_ff <= emit_ff + 1'b1;
            k_ff    <= k_ff + 1'b1;
         end
         default: ;
      endcase
   end

   assign clear_done = state_ff != B_CLEAR;
   assign rsp_valid  = out_v_ff;
   assign rsp        = out_ff;

   `UGNB_ASSERT_IMPL(a_count_cap, clock, reset, cnt_wr_en, cnt_wr_data <= CAP_CNT, "count over capacity")
   `UGNB_ASSERT_IMPL(a_quiet_clear, clock, reset, state_ff == B_CLEAR, !out_v_ff && !cmd_ready, "activity during clear")
   `UGNB_ASSERT_NEXT(a_emit_bound, clock, reset, state_ff == B_QDAT, emit_ff <= total_ff, "query emitted too many")

endmodule

/* hw/rtl/uniform_grid_neighbor_binning.sv */
// Top level of the uniform grid neighbor binning block.
// Depends on ugnb_pkg, ugnb_front, ugnb_queue and ugnb_back.
//
//   channel  direction  tdata                         tuser      tlast
//   req_     in         item, x, y                    mode       -
//   rsp_     out        neighbor index                status     last
//   csr_     in         write enable, index, value    -          -
//
// Steps: the front end runs a per-bit restoring divider for column and
// row side by side, then forms the row product and classifies the cells.
// The back end handles one command at a time: an add reads the home count
// and appends; a remove reads and compares each stored entry, packing kept
// ones down; a query reads four cell counts, then emits each stored entry.
// Reset: a clearing pass zeroes the cell counts with req_tready low;
// configuration writes are taken throughout.
// Stalls: a two-deep command queue lets the front end accept while the
// back end waits on rsp_tready.
module uniform_grid_neighbor_binning import ugnb_pkg::*; #(
   parameter int MAX_CELLS     = 1024,
   parameter int CELL_CAPACITY = 16,
   parameter int MAX_ITEMS     = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [63:0]          req_tdata,   // item_index[11:0], x_pos[35:12], y_pos[59:36]
   input  logic [1:0]           req_tuser,   // mode[1:0]
   // result channel
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [15:0]          rsp_tdata,   // neighbor_index[11:0]
   output logic [STATUS_W-1:0]  rsp_tuser,   // status[2:0]
   output logic                 rsp_tlast,
   // configuration write port
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   cfg_type cfg_ff;
   logic    clear_done;
   logic    f_valid, f_ready, b_valid, b_ready;
   cmd_type f_cmd, b_cmd;
   rsp_type rsp;

   // configuration registers; an unused index is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cell_size        <= CFG_W'(32);
         cfg_ff.cells_per_row    <= CFG_W'(32);
         cfg_ff.cells_per_column <= CFG_W'(32);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CELL_SIZE:        cfg_ff.cell_size        <= csr_wdata;
            CSR_CELLS_PER_ROW:    cfg_ff.cells_per_row    <= csr_wdata;
            CSR_CELLS_PER_COLUMN: cfg_ff.cells_per_column <= csr_wdata;
            default: ;
         endcase
      end
   end

   ugnb_front #(.MAX_CELLS(MAX_CELLS), .MAX_ITEMS(MAX_ITEMS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .clear_done (clear_done),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_mode   (mode_type'(req_tuser)),
      .req_item   (req_tdata[11:0]),
      .req_x      (req_tdata[35:12]),
      .req_y      (req_tdata[59:36]),
      .cmd_valid  (f_valid),
      .cmd_ready  (f_ready),
      .cmd        (f_cmd)
   );

   ugnb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_cmd    (f_cmd),
      .out_valid (b_valid),
      .out_ready (b_ready),
      .out_cmd   (b_cmd)
   );

   ugnb_back #(.MAX_CELLS(MAX_CELLS), .CELL_CAPACITY(CELL_CAPACITY)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (b_valid),
      .cmd_ready  (b_ready),
      .cmd        (b_cmd),
      .clear_done (clear_done),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tdata = {4'b0, rsp.index};
   assign rsp_tuser = rsp.status;
   assign rsp_tlast = rsp.last;

endmodule
